// ===== hw/rtl/ltc_pkg.sv =====
// Package for the lexical token classifier.
// Holds the item structs, class codes and keyword tables; no dependencies.
`timescale 1ns / 1ps

package ltc_pkg;

    localparam int LEN_W    = 7;
    localparam int KW_COUNT = 5;
    localparam int KW_SLOTS = 6;

    localparam logic [2:0] CLASS_PUNCT     = 3'd0;
    localparam logic [2:0] CLASS_KEYWORD   = 3'd1;
    localparam logic [2:0] CLASS_CONSTANT  = 3'd2;
    localparam logic [2:0] CLASS_OPERATOR  = 3'd3;
    localparam logic [2:0] CLASS_IDENT     = 3'd4;
    localparam logic [2:0] CLASS_BAD_IDENT = 3'd5;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    // int, float, double, string, char
    localparam logic [0:KW_COUNT-1][0:KW_SLOTS-1][7:0] KW_TEXT = '{
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
        '{"f", "l", "o", "a", "t", 8'h00},
        '{"d", "o", "u", "b", "l", "e"},
        '{"s", "t", "r", "i", "n", "g"},
        '{"c", "h", "a", "r", 8'h00, 8'h00}
    };
    localparam logic [0:KW_COUNT-1][LEN_W-1:0] KW_SIZE = '{
        7'd3, 7'd5, 7'd6, 7'd6, 7'd4
    };

    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
    } char_item_t;

    typedef struct packed {
        logic [2:0]       token_class;
        logic [LEN_W-1:0] token_length;
    } token_item_t;

    typedef struct packed {
        logic [LEN_W-1:0]    len;
        logic [7:0]          first_char;
        logic [7:0]          last_char;
        logic                all_digits;
        logic                has_forbidden;
        logic [KW_COUNT-1:0] kw_match;
    } token_state_t;

endpackage

// ===== hw/rtl/ltc_classifier.sv =====
// Token class decode from the tracked token state.
// Depends on ltc_pkg.
`timescale 1ns / 1ps

module ltc_classifier
(
    input  ltc_pkg::token_state_t tok,
    output logic [2:0]            token_class
);

    logic                         single;
    logic [ltc_pkg::KW_COUNT-1:0] kw_hit;
    logic                         is_punct;
    logic                         is_quoted;
    logic                         is_op;
    logic                         is_ident_start;
    logic [7:0]                   c0;

    assign c0     = tok.first_char;
    assign single = (tok.len == ltc_pkg::LEN_W'(1));

    always_comb
    begin
        for (int k = 0; k < ltc_pkg::KW_COUNT; k++)
        begin
            kw_hit[k] = tok.kw_match[k] && (tok.len == ltc_pkg::KW_SIZE[k]);
        end
    end

    assign is_punct = single && (c0 == ";" || c0 == "(" || c0 == ")" || c0 == "{" ||
                                 c0 == "}" || c0 == "[" || c0 == "]");
    assign is_quoted = (tok.len >= ltc_pkg::LEN_W'(2)) && (c0 == tok.last_char) &&
                       (c0 == ltc_pkg::CH_DQUOTE || c0 == ltc_pkg::CH_SQUOTE);
    assign is_op = single && (c0 == "+" || c0 == "-" || c0 == "*" || c0 == "/" ||
                              c0 == "%" || c0 == "=");
    assign is_ident_start = (c0 == "_") || (c0 >= "a" && c0 <= "z") ||
                            (c0 >= "A" && c0 <= "Z");

    always_comb
    begin
        priority if (is_punct)
            token_class = ltc_pkg::CLASS_PUNCT;
        else if (|kw_hit)
            token_class = ltc_pkg::CLASS_KEYWORD;
        else if (is_quoted || tok.all_digits)
            token_class = ltc_pkg::CLASS_CONSTANT;
        else if (is_op)
            token_class = ltc_pkg::CLASS_OPERATOR;
        else if (is_ident_start && !tok.has_forbidden)
            token_class = ltc_pkg::CLASS_IDENT;
        else
            token_class = ltc_pkg::CLASS_BAD_IDENT;
    end

endmodule

// ===== hw/rtl/lexical_token_classifier_unit.sv =====
// Lexical token classifier top level: character input register, token tracking, result register.
// Depends on ltc_pkg and ltc_classifier.
// A token's result is registered as the item that closes it leaves the input register.
// Throughput: one character item per cycle; the input register advances whenever the
// result register is free, being taken, or the character closes no token.
// Reset (rst_n low, asynchronous): both registers empty and the token state cleared.
`timescale 1ns / 1ps

module lexical_token_classifier_unit
#(
    parameter int MAX_TOKEN_LEN = 64
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      char_valid,
    output logic                      char_ready,
    input  ltc_pkg::char_item_t       char_item,
    output logic                      token_valid,
    input  logic                      token_ready,
    output ltc_pkg::token_item_t      token_item
);

    localparam logic [ltc_pkg::LEN_W-1:0] MAX_LEN = ltc_pkg::LEN_W'(MAX_TOKEN_LEN);

    logic                  char_valid_reg;
    ltc_pkg::char_item_t   char_reg;
    ltc_pkg::token_state_t tok_reg;
    ltc_pkg::token_state_t tok_next;
    ltc_pkg::token_state_t tok_upd;
    ltc_pkg::token_state_t tok_clear;
    logic                  token_valid_reg;
    logic                  token_valid_next;
    ltc_pkg::token_item_t  token_reg;
    logic [2:0]            upd_class;
    logic                  not_space;
    logic                  close;
    logic                  emit;
    logic                  advance;

    assign tok_clear = '{len: '0, first_char: '0, last_char: '0, all_digits: 1'b1,
                         has_forbidden: 1'b0, kw_match: '1};

    assign not_space = (char_reg.ch != ltc_pkg::CH_SPACE);
    assign close     = !not_space || char_reg.line_end;

    always_comb
    begin
        tok_upd = tok_reg;
        if (not_space)
        begin
            if (tok_reg.len == '0)
                tok_upd.first_char = char_reg.ch;
            tok_upd.last_char = char_reg.ch;
            for (int k = 0; k < ltc_pkg::KW_COUNT; k++)
            begin
                if (!(tok_reg.len < ltc_pkg::KW_SIZE[k] &&
                      ltc_pkg::KW_TEXT[k][tok_reg.len[2:0]] == char_reg.ch))
                    tok_upd.kw_match[k] = 1'b0;
            end
            if (char_reg.ch < "0" || char_reg.ch > "9")
                tok_upd.all_digits = 1'b0;
            if (char_reg.ch == "!" || char_reg.ch == "%" || char_reg.ch == "#" ||
                char_reg.ch == "-")
                tok_upd.has_forbidden = 1'b1;
            if (tok_reg.len < MAX_LEN)
                tok_upd.len = tok_reg.len + ltc_pkg::LEN_W'(1);
        end
    end

    ltc_classifier u_classifier
    (
        .tok         (tok_upd),
        .token_class (upd_class)
    );

    assign emit       = close && (tok_upd.len != '0);
    assign advance    = char_valid_reg && (!emit || !token_valid_reg || token_ready);
    assign char_ready = !char_valid_reg || advance;
    assign tok_next   = close ? tok_clear : tok_upd;

    always_comb
    begin
        token_valid_next = token_valid_reg && !token_ready;
        if (advance && emit)
            token_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg  <= 1'b0;
            token_valid_reg <= 1'b0;
            tok_reg         <= tok_clear;
        end
        else
        begin
            if (char_ready)
                char_valid_reg <= char_valid;
            token_valid_reg <= token_valid_next;
            if (advance)
                tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && char_ready)
            char_reg <= char_item;
        if (advance && emit)
        begin
            token_reg.token_class  <= upd_class;
            token_reg.token_length <= tok_upd.len;
        end
    end

    assign token_valid = token_valid_reg;
    assign token_item  = token_reg;

endmodule

// ===== hw/rtl/ltc_checker.sv =====
// Port-level checks for the lexical token classifier, bound to the top level.
// Depends on ltc_pkg and lexical_token_classifier_unit.
`timescale 1ns / 1ps

module ltc_checker
#(
    parameter int MAX_TOKEN_LEN = 64
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 char_ready,
    input logic                 token_valid,
    input logic                 token_ready,
    input ltc_pkg::token_item_t token_item
);

    // hold a stalled item
    a_token_hold: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && !token_ready |=> token_valid && $stable(token_item))
        else $error("token item changed while stalled");

    a_length_range: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid |-> token_item.token_length != '0 &&
                        token_item.token_length <= ltc_pkg::LEN_W'(MAX_TOKEN_LEN) &&
                        token_item.token_class <= ltc_pkg::CLASS_BAD_IDENT)
        else $error("token length or class out of range");

    a_single_char: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && (token_item.token_class == ltc_pkg::CLASS_PUNCT ||
                        token_item.token_class == ltc_pkg::CLASS_OPERATOR)
        |-> token_item.token_length == ltc_pkg::LEN_W'(1))
        else $error("punctuation or operator longer than one item");

    a_keyword_len: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_item.token_class == ltc_pkg::CLASS_KEYWORD
        |-> token_item.token_length >= ltc_pkg::LEN_W'(3) &&
            token_item.token_length <= ltc_pkg::LEN_W'(6))
        else $error("keyword with impossible length");

    // accept input whenever no result is waiting
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !token_valid |-> char_ready)
        else $error("input stalled with no result waiting");

endmodule

bind lexical_token_classifier_unit ltc_checker #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_ltc_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .char_ready  (char_ready),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token_item  (token_item)
);
